// File: rtl/dacu_pkg.sv
// ----------------------------------------------------------------------------
// dacu_pkg: shared types and constants of the deadline-aware window update
// Register indexes, reset values, the sequencer states and the divider
// request bundle.
// ----------------------------------------------------------------------------
package dacu_pkg;

  localparam int unsigned DivW   = 72;   // dividend and quotient width
  localparam int unsigned DsorW  = 32;   // divisor width
  localparam int unsigned CntW   = 7;    // holds DivW

  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

  localparam logic [1:0] REG_DEADLINE_EN = 2'd0;
  localparam logic [1:0] REG_SEG_SIZE    = 2'd1;
  localparam logic [1:0] REG_BOOST_RATIO = 2'd2;

  localparam logic [15:0] SEG_RESET   = 16'd1448;
  localparam logic [11:0] RATIO_RESET = 12'd768;
  localparam logic [11:0] RATIO_MIN   = 12'd257;
  localparam logic [11:0] RATIO_ONE   = 12'd256;

  localparam logic OP_ACK  = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  localparam logic [CntW-1:0] NB_MULDIV = 7'd72;
  localparam logic [CntW-1:0] NB_BOOST  = 7'd40;
  localparam logic [CntW-1:0] NB_PLAIN  = 7'd32;
  localparam logic [CntW-1:0] NB_AVOID  = 7'd48;

  typedef enum logic [4:0] {
    S_IDLE, S_MUL_HI, S_MUL_LO, S_MD_START, S_MD_WAIT,
    S_SS_CHK, S_SS_M1, S_SS_M2, S_SS_M3, S_SS_ADD, S_SS_START, S_SS_WAIT,
    S_AV_CHK, S_AV_M1, S_AV_START, S_AV_WAIT, S_AV_M3, S_AV_FIN, S_DONE
  } state_t;

  // Dividend is left aligned: its top nbits bits are divided.
  typedef struct packed {
    logic             start;
    logic [DivW-1:0]  dividend;
    logic [DsorW-1:0] divisor;
    logic [CntW-1:0]  nbits;
  } div_req_t;

endpackage

// File: rtl/dacu_div.sv
// ----------------------------------------------------------------------------
// dacu_div: shared restoring divider
// One quotient bit per cycle over a left-aligned dividend of up to 72 bits.
// ----------------------------------------------------------------------------
module dacu_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dacu_pkg::div_req_t          req,
  output logic                        done,
  output logic [dacu_pkg::DivW-1:0]   quotient
);
  import dacu_pkg::*;

  logic [DivW-1:0]  dvd_r, dvd_nxt;
  logic [DsorW-1:0] rem_r, rem_nxt, dsor_r, dsor_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt;
  logic [DsorW:0]   trial;
  logic             ge;

  always_comb begin
    trial    = {rem_r, dvd_r[DivW-1]};
    ge       = trial >= {1'b0, dsor_r};
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsor_nxt = dsor_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      dvd_nxt  = req.dividend;
      dsor_nxt = req.divisor;
      rem_nxt  = '0;
      cnt_nxt  = req.nbits;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // The remainder stays below the divisor, so it fits the divisor width.
      rem_nxt = ge ? DsorW'(trial - {1'b0, dsor_r}) : trial[DsorW-1:0];
      dvd_nxt = {dvd_r[DivW-2:0], ge};
      cnt_nxt = cnt_r - CntW'(1);
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    dsor_r <= dsor_nxt;
    cnt_r  <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

// File: rtl/deadline_aware_cwnd_update.sv
// ----------------------------------------------------------------------------
// deadline_aware_cwnd_update: congestion window update per acknowledgement
// A sequencer drives one 32x32 multiplier and one serial divider.
// ----------------------------------------------------------------------------
// A load goes straight to S_DONE; an ack event runs the sequencer through its
// multiply and divide states, whose length is set by the serial divider
// (72, 40 or 32, and 48 quotient bits for its three divides).
// One transaction at a time; in_tready is high only when idle, and a result
// held by out_tready delays the return to idle.
// Reset (rst_n low, synchronous) clears the window to zero, sets the
// registers to 0, 1448 and 768 and empties the result register.
module deadline_aware_cwnd_update (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  // acked_segments, slow_start_threshold, bytes_left, time_left_us, rtt_us,
  // new_window
  input  logic [183:0] in_tdata,
  // op
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // window, min_window, acks_left, was_slow_start, zero fill
  output logic [87:0]  out_tdata
);
  import dacu_pkg::*;

  state_t state_r, state_nxt;

  logic        dl_en_r, dl_en_nxt;
  logic [15:0] seg_r, seg_nxt;
  logic [11:0] ratio_r, ratio_nxt;

  logic [31:0] cwnd_r, cwnd_nxt;
  logic [15:0] acks_r, acks_nxt;
  logic [31:0] ssth_r, ssth_nxt;
  logic [47:0] left_r, left_nxt;
  logic [31:0] tl_r, tl_nxt;
  logic [23:0] rtt_r, rtt_nxt;
  logic [31:0] wmin_r, wmin_nxt;
  logic        ss_r, ss_nxt;
  logic        under_r, under_nxt;
  logic [47:0] prod_r, prod_nxt;
  logic [71:0] acc_r, acc_nxt;
  logic [31:0] dsor_r, dsor_nxt;
  logic [31:0] diff_r, diff_nxt;
  logic [31:0] add_r, add_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [87:0] out_data_r, out_data_nxt;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [15:0] seg;
  logic [11:0] rc, rm;
  logic [12:0] kf;
  logic [47:0] inc;
  logic [48:0] sum49;
  logic [31:0] nw_sat, nw;
  logic [32:0] sum33;
  logic [31:0] bst, add2;

  div_req_t    dreq;
  logic        ddone;
  logic [71:0] dq;

  dacu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (dreq),
    .done     (ddone),
    .quotient (dq)
  );

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    dl_en_nxt = dl_en_r;
    seg_nxt   = seg_r;
    ratio_nxt = ratio_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_DEADLINE_EN: dl_en_nxt = cfg_data[0];
        REG_SEG_SIZE:    seg_nxt   = cfg_data;
        REG_BOOST_RATIO: ratio_nxt = cfg_data[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    seg = (seg_r == '0) ? 16'd1 : seg_r;
    rc  = (ratio_r < RATIO_MIN) ? RATIO_MIN : ratio_r;
    rm  = rc - RATIO_ONE;
    kf  = {rm, 1'b0} + 13'd256;

    inc    = under_r ? {8'b0, prod_r[47:8]} : prod_r;
    sum49  = {17'b0, cwnd_r} + {1'b0, inc};
    nw_sat = (|sum49[48:32]) ? SAT32 : sum49[31:0];
    nw     = (nw_sat > ssth_r) ? ssth_r + 32'd1 : nw_sat;

    bst   = {12'b0, prod_r[27:8]};
    sum33 = {1'b0, add_r} + {1'b0, bst};
    add2  = (cwnd_r < wmin_r) ? (sum33[32] ? SAT32 : sum33[31:0]) : add_r;

    mul_a = '0;
    mul_b = '0;
    dreq  = '0;

    state_nxt = state_r;
    in_tready = 1'b0;
    cwnd_nxt  = cwnd_r;
    acks_nxt  = acks_r;
    ssth_nxt  = ssth_r;
    left_nxt  = left_r;
    tl_nxt    = tl_r;
    rtt_nxt   = rtt_r;
    wmin_nxt  = wmin_r;
    ss_nxt    = ss_r;
    under_nxt = under_r;
    prod_nxt  = prod_r;
    acc_nxt   = acc_r;
    dsor_nxt  = dsor_r;
    diff_nxt  = diff_r;
    add_nxt   = add_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          acks_nxt = in_tdata[15:0];
          ssth_nxt = in_tdata[47:16];
          left_nxt = in_tdata[95:48];
          tl_nxt   = in_tdata[127:96];
          rtt_nxt  = in_tdata[151:128];
          ss_nxt   = 1'b0;
          if (in_tuser == OP_LOAD) begin
            cwnd_nxt  = in_tdata[183:152];
            wmin_nxt  = '0;
            acks_nxt  = '0;
            state_nxt = S_DONE;
          end else if (dl_en_r && in_tdata[127:96] != '0 && !in_tdata[127]) begin
            state_nxt = S_MUL_HI;
          end else begin
            wmin_nxt  = dl_en_r ? cwnd_r : '0;
            state_nxt = S_SS_CHK;
          end
        end
      end
      S_MUL_HI: begin
        mul_a     = {8'b0, left_r[47:24]};
        mul_b     = {8'b0, rtt_r};
        state_nxt = S_MUL_LO;
      end
      S_MUL_LO: begin
        mul_a     = {8'b0, left_r[23:0]};
        mul_b     = {8'b0, rtt_r};
        acc_nxt   = {prod_r, 24'b0};
        state_nxt = S_MD_START;
      end
      S_MD_START: begin
        dreq.start    = 1'b1;
        dreq.dividend = acc_r + {24'b0, prod_r};
        dreq.divisor  = tl_r;
        dreq.nbits    = NB_MULDIV;
        state_nxt     = S_MD_WAIT;
      end
      S_MD_WAIT: begin
        if (ddone) begin
          wmin_nxt  = (|dq[71:32]) ? SAT32 : dq[31:0];
          state_nxt = S_SS_CHK;
        end
      end
      S_SS_CHK: begin
        state_nxt = S_AV_CHK;
        if (cwnd_r < ssth_r) begin
          ss_nxt = 1'b1;
          if (acks_r != '0) begin
            under_nxt = cwnd_r < wmin_r;
            state_nxt = S_SS_M1;
          end
        end
      end
      S_SS_M1: begin
        mul_a     = under_r ? {20'b0, rm} : {16'b0, acks_r};
        mul_b     = {16'b0, seg};
        state_nxt = S_SS_M2;
      end
      S_SS_M2: begin
        dsor_nxt  = under_r ? {prod_r[30:0], 1'b0} : {16'b0, seg};
        mul_a     = {19'b0, kf};
        mul_b     = {16'b0, seg};
        state_nxt = S_SS_M3;
      end
      S_SS_M3: begin
        mul_a     = prod_r[31:0];
        mul_b     = {16'b0, acks_r};
        state_nxt = S_SS_ADD;
      end
      S_SS_ADD: begin
        cwnd_nxt  = nw;
        diff_nxt  = nw - cwnd_r;
        state_nxt = S_SS_START;
      end
      S_SS_START: begin
        dreq.start    = 1'b1;
        dreq.dividend = under_r ? {diff_r, 8'b0, 32'b0} : {diff_r, 40'b0};
        dreq.divisor  = dsor_r;
        dreq.nbits    = under_r ? NB_BOOST : NB_PLAIN;
        state_nxt     = S_SS_WAIT;
      end
      S_SS_WAIT: begin
        if (ddone) begin
          acks_nxt  = (dq >= {56'b0, acks_r}) ? '0 : acks_r - dq[15:0];
          state_nxt = S_AV_CHK;
        end
      end
      S_AV_CHK: begin
        state_nxt = S_DONE;
        if (cwnd_r >= ssth_r && acks_r != '0) begin
          if (cwnd_r == '0) begin
            // An empty window makes the per-ack share unbounded.
            add_nxt   = SAT32;
            state_nxt = S_AV_M3;
          end else begin
            mul_a     = {16'b0, seg};
            mul_b     = {16'b0, seg};
            state_nxt = S_AV_M1;
          end
        end
      end
      S_AV_M1: begin
        mul_a     = prod_r[31:0];
        mul_b     = {16'b0, acks_r};
        state_nxt = S_AV_START;
      end
      S_AV_START: begin
        dreq.start    = 1'b1;
        dreq.dividend = {prod_r, 24'b0};
        dreq.divisor  = cwnd_r;
        dreq.nbits    = NB_AVOID;
        state_nxt     = S_AV_WAIT;
      end
      S_AV_WAIT: begin
        if (ddone) begin
          if (|dq[71:32])      add_nxt = SAT32;
          else if (dq == '0)   add_nxt = 32'd1;
          else                 add_nxt = dq[31:0];
          state_nxt = S_AV_M3;
        end
      end
      S_AV_M3: begin
        mul_a     = {20'b0, rm};
        mul_b     = {16'b0, seg};
        state_nxt = S_AV_FIN;
      end
      S_AV_FIN: begin
        sum33     = {1'b0, cwnd_r} + {1'b0, add2};
        cwnd_nxt  = sum33[32] ? SAT32 : sum33[31:0];
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {7'b0, ss_r, acks_r, wmin_r, cwnd_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    mul_p = mul_a * mul_b;
    if (state_r == S_MUL_HI || state_r == S_MUL_LO || state_r == S_SS_M1 ||
        state_r == S_AV_M1 || state_r == S_AV_M3 ||
        (state_r == S_AV_CHK && state_nxt == S_AV_M1) ||
        ((state_r == S_SS_M2 || state_r == S_SS_M3) && under_r)) begin
      prod_nxt = mul_p[47:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dl_en_r     <= 1'b0;
      seg_r       <= SEG_RESET;
      ratio_r     <= RATIO_RESET;
      cwnd_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dl_en_r     <= dl_en_nxt;
      seg_r       <= seg_nxt;
      ratio_r     <= ratio_nxt;
      cwnd_r      <= cwnd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acks_r     <= acks_nxt;
    ssth_r     <= ssth_nxt;
    left_r     <= left_nxt;
    tl_r       <= tl_nxt;
    rtt_r      <= rtt_nxt;
    wmin_r     <= wmin_nxt;
    ss_r       <= ss_nxt;
    under_r    <= under_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    dsor_r     <= dsor_nxt;
    diff_r     <= diff_nxt;
    add_r      <= add_nxt;
    out_data_r <= out_data_nxt;
  end

  a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    ddone |-> (state_r == S_MD_WAIT || state_r == S_SS_WAIT || state_r == S_AV_WAIT))
    else $error("divider finished while no divide was pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken again before the event finished");

  a_ss_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SS_WAIT) |-> ({1'b0, cwnd_r} <= {1'b0, ssth_r} + 33'd1))
    else $error("slow start overran the threshold clamp");

endmodule
